// ===== hw/rtl/cevq_pkg.sv =====
package cevq_pkg;

   // field widths of the transactions
   localparam int unsigned ID_BITS      = 16;
   localparam int unsigned DATA_BITS    = 32;
   localparam int unsigned STATUS_BITS  = 3;
   localparam int unsigned FILL_BITS    = 5;
   localparam int unsigned CSR_IDX_BITS = 8;

   // operation codes
   localparam logic ACT_POST = 1'b0;
   localparam logic ACT_TAKE = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_QUEUED    = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_COALESCED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DELIVERED = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_REDRAW_ID    = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANIMATION_ID = 8'd1;

   // register reset values
   localparam logic [ID_BITS-1:0] REDRAW_ID_RESET    = 16'd1;
   localparam logic [ID_BITS-1:0] ANIMATION_ID_RESET = 16'd2;

   // pending mark bits
   localparam logic [1:0] MARK_NONE      = 2'b00;
   localparam logic [1:0] MARK_REDRAW    = 2'b01;
   localparam logic [1:0] MARK_ANIMATION = 2'b10;

   typedef struct packed {
      logic                 action;
      logic [ID_BITS-1:0]   event_id;
      logic [DATA_BITS-1:0] event_payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0]     out_id;
      logic [DATA_BITS-1:0]   out_payload;
      logic [FILL_BITS-1:0]   fill_level;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0] redraw_id;
      logic [ID_BITS-1:0] animation_id;
   } kind_ids_type;

   // redraw wins when both registers hold the same id
   function automatic logic [1:0] kind_mark(input logic [ID_BITS-1:0] id,
                                            input kind_ids_type ids);
      logic [1:0] mark;
      mark = MARK_NONE;
      if (id == ids.redraw_id) begin
         mark = MARK_REDRAW;
      end else if (id == ids.animation_id) begin
         mark = MARK_ANIMATION;
      end
      return mark;
   endfunction

endpackage

// ===== hw/rtl/coalescing_event_queue.sv =====
// channel   ports                         direction  payload
// request   req_valid req_ready req_data  in         cevq_pkg::req_type
// response  rsp_valid rsp_ready rsp_data  out        cevq_pkg::rsp_type
// csr       csr_valid csr_ready           in         csr_index, csr_wdata
//
// a post has its result registered at the accepting edge
// a take on a non-empty queue goes through the registered slot ram read, then the result register
// a take on an empty queue has its result registered at the accepting edge
// a new transaction is accepted once no slot read is outstanding and the response register is free or being drained
// reset clears pointers, count, pending marks and registers; slot ram is not cleared
module coalescing_event_queue #(
   parameter int unsigned QUEUE_DEPTH  = 16,
   parameter int unsigned PAYLOAD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cevq_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cevq_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cevq_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [cevq_pkg::ID_BITS-1:0]      csr_wdata
);

   import cevq_pkg::*;

   localparam int unsigned AW         = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned STORE_BITS = (PAYLOAD_BITS < DATA_BITS) ? PAYLOAD_BITS : DATA_BITS;
   localparam int unsigned SLOT_BITS  = ID_BITS + STORE_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   kind_ids_type ids;

   logic          state_ff, state_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    pending_ff, pending_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic                 req_fire;
   logic [1:0]           post_mark;
   logic [1:0]           take_mark;
   logic [CW:0]          wr_sum;
   logic [CW:0]          wr_wrap;
   logic [AW-1:0]        wr_addr;
   logic                 wr_en;
   logic                 rd_en;
   logic [SLOT_BITS-1:0] slot_wdata;
   logic [SLOT_BITS-1:0] slot_rdata;
   logic [ID_BITS-1:0]   slot_id;
   logic [STORE_BITS-1:0] slot_payload;

   // configuration registers
   cevq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ids       (ids)
   );

   assign csr_ready = 1'b1;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // tail slot: head plus count, wrapped once
   assign wr_sum  = (CW+1)'(rd_ptr_ff) + (CW+1)'(count_ff);
   assign wr_wrap = (wr_sum >= (CW+1)'(QUEUE_DEPTH)) ? wr_sum - (CW+1)'(QUEUE_DEPTH) : wr_sum;
   assign wr_addr = wr_wrap[AW-1:0];

   assign post_mark    = kind_mark(req_data.event_id, ids);
   assign slot_wdata   = {req_data.event_id, req_data.event_payload[STORE_BITS-1:0]};
   assign slot_id      = slot_rdata[SLOT_BITS-1:STORE_BITS];
   assign slot_payload = slot_rdata[STORE_BITS-1:0];
   assign take_mark    = kind_mark(slot_id, ids);

   // slot storage
   cevq_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (slot_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (slot_rdata)
   );

   // queue control and result formation
   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      priority if (state_ff == ST_READ) begin
         // slot data is back, finish the take
         pending_in         = pending_ff & ~take_mark;
         rsp_in.status      = ST_DELIVERED;
         rsp_in.out_id      = slot_id;
         rsp_in.out_payload = DATA_BITS'(slot_payload);
         rsp_in.fill_level  = FILL_BITS'(count_ff);
         rsp_valid_in       = 1'b1;
         state_in           = ST_IDLE;
      end else if (req_fire && req_data.action == ACT_POST) begin
         rsp_in.out_id      = '0;
         rsp_in.out_payload = '0;
         rsp_valid_in       = 1'b1;
         priority if ((post_mark & pending_ff) != MARK_NONE) begin
            rsp_in.status = ST_COALESCED;
         end else if (count_ff < CW'(QUEUE_DEPTH)) begin
            wr_en         = 1'b1;
            count_in      = count_ff + CW'(1);
            pending_in    = pending_ff | post_mark;
            rsp_in.status = ST_QUEUED;
         end else begin
            rsp_in.status = ST_OVERFLOW;
         end
         rsp_in.fill_level = FILL_BITS'(count_in);
      end else if (req_fire) begin
         if (count_ff == '0) begin
            rsp_in.status      = ST_EMPTY;
            rsp_in.out_id      = '0;
            rsp_in.out_payload = '0;
            rsp_in.fill_level  = FILL_BITS'(count_ff);
            rsp_valid_in       = 1'b1;
         end else begin
            rd_en     = 1'b1;
            count_in  = count_ff - CW'(1);
            rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
            state_in  = ST_READ;
         end
      end else begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pending_ff   <= MARK_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the count never runs past the ring
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // an accepted take on a non-empty queue always enters the read state
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.action == ACT_TAKE && count_ff != '0) |=> state_ff == ST_READ)
      else $error("take did not start a slot read");

   // a finished slot read always produces a response
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> (rsp_valid_ff && rsp_ff.status == ST_DELIVERED))
      else $error("slot read produced no delivery");

   // no request is taken while a slot read is outstanding
   assert property (@(posedge clock) disable iff (reset) state_ff == ST_READ |-> !req_ready)
      else $error("request accepted during slot read");

endmodule

// ===== hw/rtl/cevq_ram.sv =====
module cevq_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cevq_csr.sv =====
module cevq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [cevq_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [cevq_pkg::ID_BITS-1:0]      csr_wdata,
   output cevq_pkg::kind_ids_type            ids
);

   import cevq_pkg::*;

   kind_ids_type ids_ff;
   kind_ids_type ids_in;

   // decode register writes, unknown indexes are dropped
   always_comb begin
      ids_in = ids_ff;
      if (csr_valid) begin
         if (csr_index == CSR_REDRAW_ID) begin
            ids_in.redraw_id = csr_wdata;
         end else if (csr_index == CSR_ANIMATION_ID) begin
            ids_in.animation_id = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ids_ff.redraw_id    <= REDRAW_ID_RESET;
         ids_ff.animation_id <= ANIMATION_ID_RESET;
      end else begin
         ids_ff <= ids_in;
      end
   end

   assign ids = ids_ff;

endmodule
